FILE: src/distance_transform_skeleton_top_defines.svh
// Assertion macros shared by the RTL.
`ifndef DISTANCE_TRANSFORM_SKELETON_TOP_DEFINES_SVH
`define DISTANCE_TRANSFORM_SKELETON_TOP_DEFINES_SVH

// Same-cycle implication, checked on i_clk, off during reset.
`define DTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk, off during reset.
`define DTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dts_pkg.sv
package dts_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 256;
    localparam int unsigned DEF_MAX_HEIGHT = 256;

    localparam int unsigned OPCODE_W   = 2;
    localparam int unsigned COORD_W    = 8;
    localparam int unsigned DIST_W     = 8;
    localparam int unsigned SUM_W      = DIST_W + 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 9;

    localparam logic [CFG_DATA_W-1:0] IMG_DIM_RESET = 9'd256;
    localparam logic [DIST_W-1:0]     DIST_MAX      = 8'hFF;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PASS,
        S_READ,
        S_EMIT
    } t_state;

    // pass phase: fetch current pixel + write back previous, or fetch neighbor
    typedef enum logic {
        PH_CUR,
        PH_NB
    } t_phase;

    // read sequence probes
    typedef enum logic [2:0] {
        PR_CENTER = 3'd0,
        PR_WEST   = 3'd1,
        PR_EAST   = 3'd2,
        PR_NORTH  = 3'd3,
        PR_SOUTH  = 3'd4,
        PR_LAST   = 3'd5
    } t_probe;

endpackage

FILE: src/dts_channels_if.sv
interface dts_item_if;
    logic                           valid;
    logic                           ready;
    logic [dts_pkg::OPCODE_W-1:0]   opcode;
    logic [dts_pkg::COORD_W-1:0]    pixel_row;
    logic [dts_pkg::COORD_W-1:0]    pixel_col;
    logic                           pixel_on;

    modport source (output valid, output opcode, output pixel_row, output pixel_col,
                    output pixel_on, input ready);
    modport sink   (input valid, input opcode, input pixel_row, input pixel_col,
                    input pixel_on, output ready);
endinterface

interface dts_result_if;
    logic                           valid;
    logic                           ready;
    logic [dts_pkg::DIST_W-1:0]     distance_value;
    logic [dts_pkg::DIST_W-1:0]     skeleton_value;
    logic                           status;

    modport source (output valid, output distance_value, output skeleton_value,
                    output status, input ready);
    modport sink   (input valid, input distance_value, input skeleton_value,
                    input status, output ready);
endinterface

interface dts_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dts_pkg::CFG_IDX_W-1:0]    index;
    logic [dts_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/distance_transform_skeleton_top.sv
// Channel   Dir  Beat payload
// i_in      in   opcode, pixel_row, pixel_col, pixel_on
// o_out     out  distance_value, skeleton_value, status
// i_cfg     in   index, data (image_width, image_height)
//
// Write, bad opcode or out-of-image read go from IDLE straight to EMIT. Read: 5 map reads.
// Run: both passes share one map read port; each pixel takes a current phase and a neighbor phase.
// i_rst_n is synchronous; the map itself is not cleared.
// A held result in o_out does not block the next item; only the result load waits.
module distance_transform_skeleton_top #(
    parameter int unsigned MAX_WIDTH  = dts_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = dts_pkg::DEF_MAX_HEIGHT
) (
    input logic          i_clk,
    input logic          i_rst_n,
    dts_item_if.sink     i_in,
    dts_result_if.source o_out,
    dts_cfg_if.sink      i_cfg
);
    import dts_pkg::*;
    `include "distance_transform_skeleton_top_defines.svh"

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;
    localparam int XWA   = $clog2(MAX_WIDTH + 1);
    localparam int XHA   = $clog2(MAX_HEIGHT + 1);
    localparam int XWB   = (XWA > XHA) ? XWA : XHA;
    localparam int XW    = (XWB > CFG_DATA_W) ? XWB : CFG_DATA_W;

    function automatic logic [AW-1:0] mk_addr(input logic [XW:0] row, input logic [XW:0] col);
        mk_addr = {row[RW-1:0], col[CW-1:0]};
    endfunction

    // map
    logic [DIST_W-1:0] r_map [DEPTH];
    logic [DIST_W-1:0] r_rdata;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DIST_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_map[mem_raddr];
    end

    // config
    logic [CFG_DATA_W-1:0] r_img_w, r_img_h;
    logic [XW-1:0]         eff_w, eff_h, w_last, h_last;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= IMG_DIM_RESET;
            r_img_h <= IMG_DIM_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_WIDTH:  r_img_w <= i_cfg.data;
                CFG_HEIGHT: r_img_h <= i_cfg.data;
                default:    ;
            endcase
        end
    end

    assign eff_w  = (XW'(r_img_w) > XW'(MAX_WIDTH))  ? XW'(MAX_WIDTH)  : XW'(r_img_w);
    assign eff_h  = (XW'(r_img_h) > XW'(MAX_HEIGHT)) ? XW'(MAX_HEIGHT) : XW'(r_img_h);
    assign w_last = eff_w - XW'(1);
    assign h_last = eff_h - XW'(1);

    // sequencer state
    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    t_probe             r_step, n_step;
    logic               r_rev, n_rev;
    logic               r_pend, n_pend;
    logic               r_drain, n_drain;
    logic               r_any, n_any;
    logic [XW-1:0]      r_row, n_row, r_col, n_col;
    logic [XW-1:0]      r_prow, n_prow, r_pcol, n_pcol;
    logic [DIST_W-1:0]  r_cur, n_cur, r_prev, n_prev, r_d, n_d;
    logic               r_nb_ok, n_nb_ok, r_adj_ok, n_adj_ok, r_rd_ok, n_rd_ok;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [DIST_W-1:0]  r_res_dist, n_res_dist, r_res_skel, n_res_skel;
    logic               r_res_stat, n_res_stat;
    logic               r_out_valid, n_out_valid;
    logic [DIST_W-1:0]  r_out_dist, n_out_dist, r_out_skel, n_out_skel;
    logic               r_out_stat, n_out_stat;

    // shared min / increment / compare unit
    logic [DIST_W-1:0]  nb_v, adj_v, min_v, fwd_v, rev_v, pix_v, data_v;
    logic [DIST_W:0]    inc_v;
    logic [SUM_W-1:0]   sum_next;
    logic               skel_hit;
    logic               in_ready, in_img, last_pix;
    logic [XW-1:0]      in_row, in_col;

    assign nb_v   = r_nb_ok  ? r_rdata : '0;
    assign adj_v  = r_adj_ok ? r_prev  : '0;
    assign min_v  = (nb_v < adj_v) ? nb_v : adj_v;
    assign inc_v  = {1'b0, min_v} + (DIST_W+1)'(1);
    assign fwd_v  = (r_cur == '0) ? '0 : (inc_v[DIST_W] ? DIST_MAX : inc_v[DIST_W-1:0]);
    assign rev_v  = (inc_v < {1'b0, r_cur}) ? inc_v[DIST_W-1:0] : r_cur;
    assign pix_v  = r_rev ? rev_v : fwd_v;

    assign data_v   = r_rd_ok ? r_rdata : '0;
    assign sum_next = r_sum + SUM_W'(data_v);
    assign skel_hit = (r_d != '0) &&
                      (({1'b0, sum_next} + (SUM_W+1)'(2)) <= {1'b0, r_d, 2'b00});

    assign in_row   = XW'(i_in.pixel_row);
    assign in_col   = XW'(i_in.pixel_col);
    assign in_img   = (in_row < eff_h) && (in_col < eff_w);
    assign in_ready = (r_state == S_IDLE);
    assign last_pix = r_rev ? ((r_col == '0) && (r_row == '0))
                            : ((r_col == w_last) && (r_row == h_last));

    assign i_in.ready           = in_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.distance_value = r_out_dist;
    assign o_out.skeleton_value = r_out_skel;
    assign o_out.status         = r_out_stat;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_step      = r_step;
        n_rev       = r_rev;
        n_pend      = r_pend;
        n_drain     = r_drain;
        n_any       = r_any;
        n_row       = r_row;
        n_col       = r_col;
        n_prow      = r_prow;
        n_pcol      = r_pcol;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_d         = r_d;
        n_nb_ok     = r_nb_ok;
        n_adj_ok    = r_adj_ok;
        n_rd_ok     = r_rd_ok;
        n_sum       = r_sum;
        n_res_dist  = r_res_dist;
        n_res_skel  = r_res_skel;
        n_res_stat  = r_res_stat;
        n_out_valid = r_out_valid;
        n_out_dist  = r_out_dist;
        n_out_skel  = r_out_skel;
        n_out_stat  = r_out_stat;
        mem_we      = 1'b0;
        mem_waddr   = mk_addr({1'b0, in_row}, {1'b0, in_col});
        mem_wdata   = DIST_W'(i_in.pixel_on);
        mem_raddr   = mk_addr({1'b0, r_row}, {1'b0, r_col});

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_res_dist = '0;
                    n_res_skel = '0;
                    n_res_stat = 1'b0;
                    n_state    = S_EMIT;
                    n_row      = in_row;
                    n_col      = in_col;
                    case (t_opcode'(i_in.opcode))
                        OP_WRITE: begin
                            mem_we = in_img;
                        end
                        OP_RUN: begin
                            if (eff_w == '0 || eff_h == '0) begin
                                n_res_stat = 1'b1;
                            end else begin
                                n_state = S_PASS;
                                n_rev   = 1'b0;
                                n_phase = PH_CUR;
                                n_pend  = 1'b0;
                                n_drain = 1'b0;
                                n_any   = 1'b0;
                                n_row   = '0;
                                n_col   = '0;
                            end
                        end
                        OP_READ: begin
                            if (in_img) begin
                                n_state = S_READ;
                                n_step  = PR_CENTER;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_PASS: begin
                if (r_phase == PH_CUR) begin
                    mem_raddr = mk_addr({1'b0, r_row}, {1'b0, r_col});
                    if (r_pend) begin
                        mem_we    = 1'b1;
                        mem_waddr = mk_addr({1'b0, r_prow}, {1'b0, r_pcol});
                        mem_wdata = pix_v;
                        n_prev    = pix_v;
                        n_any     = r_any | (!r_rev && (r_cur != '0));
                        n_pend    = 1'b0;
                    end
                    if (r_drain) begin
                        n_drain = 1'b0;
                        if (!r_rev) begin
                            n_rev = 1'b1;
                            n_row = h_last;
                            n_col = w_last;
                        end else begin
                            n_res_dist = '0;
                            n_res_skel = '0;
                            n_res_stat = !r_any;
                            n_state    = S_EMIT;
                        end
                    end else begin
                        n_phase = PH_NB;
                    end
                end else begin
                    n_cur  = r_rdata;
                    n_pend = 1'b1;
                    n_prow = r_row;
                    n_pcol = r_col;
                    n_phase = PH_CUR;
                    n_drain = last_pix;
                    if (!r_rev) begin
                        mem_raddr = mk_addr({1'b0, r_row} - (XW+1)'(1), {1'b0, r_col});
                        n_nb_ok   = (r_row != '0);
                        n_adj_ok  = (r_col != '0);
                        if (r_col == w_last) begin
                            n_col = '0;
                            n_row = r_row + XW'(1);
                        end else begin
                            n_col = r_col + XW'(1);
                        end
                    end else begin
                        mem_raddr = mk_addr({1'b0, r_row} + (XW+1)'(1), {1'b0, r_col});
                        n_nb_ok   = (r_row != h_last);
                        n_adj_ok  = (r_col != w_last);
                        if (r_col == '0) begin
                            n_col = w_last;
                            n_row = r_row - XW'(1);
                        end else begin
                            n_col = r_col - XW'(1);
                        end
                    end
                end
            end

            S_READ: begin
                n_step = t_probe'(r_step + 3'd1);
                case (r_step)
                    PR_CENTER: begin
                        mem_raddr = mk_addr({1'b0, r_row}, {1'b0, r_col});
                        n_rd_ok   = 1'b1;
                    end
                    PR_WEST: begin
                        mem_raddr = mk_addr({1'b0, r_row}, {1'b0, r_col} - (XW+1)'(2));
                        n_rd_ok   = (r_col >= XW'(2));
                        n_d       = data_v;
                        n_sum     = '0;
                    end
                    PR_EAST: begin
                        mem_raddr = mk_addr({1'b0, r_row}, {1'b0, r_col} + (XW+1)'(2));
                        n_rd_ok   = (({1'b0, r_col} + (XW+1)'(2)) < {1'b0, eff_w});
                        n_sum     = sum_next;
                    end
                    PR_NORTH: begin
                        mem_raddr = mk_addr({1'b0, r_row} - (XW+1)'(2), {1'b0, r_col});
                        n_rd_ok   = (r_row >= XW'(2));
                        n_sum     = sum_next;
                    end
                    PR_SOUTH: begin
                        mem_raddr = mk_addr({1'b0, r_row} + (XW+1)'(2), {1'b0, r_col});
                        n_rd_ok   = (({1'b0, r_row} + (XW+1)'(2)) < {1'b0, eff_h});
                        n_sum     = sum_next;
                    end
                    default: begin
                        n_rd_ok    = 1'b0;
                        n_res_dist = r_d;
                        n_res_skel = skel_hit ? r_d : '0;
                        n_res_stat = 1'b0;
                        n_state    = S_EMIT;
                    end
                endcase
            end

            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_dist  = r_res_dist;
                    n_out_skel  = r_res_skel;
                    n_out_stat  = r_res_stat;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase    <= n_phase;
        r_step     <= n_step;
        r_rev      <= n_rev;
        r_pend     <= n_pend;
        r_drain    <= n_drain;
        r_any      <= n_any;
        r_row      <= n_row;
        r_col      <= n_col;
        r_prow     <= n_prow;
        r_pcol     <= n_pcol;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_d        <= n_d;
        r_nb_ok    <= n_nb_ok;
        r_adj_ok   <= n_adj_ok;
        r_rd_ok    <= n_rd_ok;
        r_sum      <= n_sum;
        r_res_dist <= n_res_dist;
        r_res_skel <= n_res_skel;
        r_res_stat <= n_res_stat;
        r_out_dist <= n_out_dist;
        r_out_skel <= n_out_skel;
        r_out_stat <= n_out_stat;
    end

    `DTS_ASSERT_NOW(a_no_write_in_read, r_state == S_READ, !mem_we, "map written during read")
    `DTS_ASSERT_NOW(a_pass_wb_phase, r_state == S_PASS && mem_we, r_phase == PH_CUR && r_pend,
                    "pass write-back outside its phase")
    `DTS_ASSERT_NOW(a_pass_in_bounds, r_state == S_PASS && !r_drain,
                    r_row < eff_h && r_col < eff_w, "pass position outside image")
    `DTS_ASSERT_NEXT(a_emit_holds, r_state == S_EMIT && r_out_valid && !o_out.ready,
                     r_state == S_EMIT, "result dropped while output stalled")

endmodule

FILE: tb/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dts_pkg::*;

    localparam int MAP_W         = DEF_MAX_WIDTH;
    localparam int MAP_H         = DEF_MAX_HEIGHT;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_REPORTS   = 10;
    localparam int SKEL_LIMIT    = -2;
    localparam int DIR_ROWS      = 28;

    localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0] dval;
        logic [DIST_W-1:0] skel;
        logic              status;
    } t_pixel_result;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [OPCODE_W-1:0]   op;
        logic [COORD_W-1:0]    row;
        logic [COORD_W-1:0]    col;
        logic                  on;
        logic                  typed;
        logic [DIST_W-1:0]     dval;
        logic [DIST_W-1:0]     skel;
        logic                  status;
    } t_dir_row;

    // typed rows: writes, out-of-image reads, unused opcode, empty run, 3x3 center
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{1'b0, CFG_WIDTH,  9'd0, OP_NONE,  8'd255, 8'd255, 1'b1, 1'b1, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_WRITE, 8'd255, 8'd255, 1'b1, 1'b1, 8'd0, 8'd0, 1'b0},
        '{1'b1, CFG_WIDTH,  9'd0, OP_NONE,  8'd0,   8'd0,   1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_RUN,   8'd0,   8'd0,   1'b0, 1'b1, 8'd0, 8'd0, 1'b1},
        '{1'b0, CFG_WIDTH,  9'd0, OP_READ,  8'd0,   8'd0,   1'b0, 1'b1, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_WRITE, 8'd0,   8'd0,   1'b1, 1'b1, 8'd0, 8'd0, 1'b0},
        '{1'b1, CFG_WIDTH,  9'd3, OP_NONE,  8'd0,   8'd0,   1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b1, CFG_HEIGHT, 9'd3, OP_NONE,  8'd0,   8'd0,   1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_WRITE, 8'd0,   8'd0,   1'b1, 1'b1, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_WRITE, 8'd0,   8'd1,   1'b1, 1'b1, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_WRITE, 8'd0,   8'd2,   1'b1, 1'b1, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_WRITE, 8'd1,   8'd0,   1'b1, 1'b1, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_WRITE, 8'd1,   8'd1,   1'b1, 1'b1, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_WRITE, 8'd1,   8'd2,   1'b1, 1'b1, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_WRITE, 8'd2,   8'd0,   1'b1, 1'b1, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_WRITE, 8'd2,   8'd1,   1'b1, 1'b1, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_WRITE, 8'd2,   8'd2,   1'b1, 1'b1, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_READ,  8'd1,   8'd1,   1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_RUN,   8'd0,   8'd0,   1'b0, 1'b1, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_READ,  8'd1,   8'd1,   1'b0, 1'b1, 8'd2, 8'd2, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_READ,  8'd0,   8'd2,   1'b1, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_READ,  8'd255, 8'd0,   1'b0, 1'b1, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_WRITE, 8'd1,   8'd1,   1'b0, 1'b1, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_RUN,   8'd0,   8'd0,   1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_READ,  8'd0,   8'd0,   1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b1, CFG_WIDTH,  9'd2, OP_NONE,  8'd0,   8'd0,   1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_READ,  8'd0,   8'd1,   1'b0, 1'b0, 8'd0, 8'd0, 1'b0},
        '{1'b0, CFG_WIDTH,  9'd0, OP_NONE,  8'd0,   8'd0,   1'b0, 1'b1, 8'd0, 8'd0, 1'b0}
    };

    logic i_clk;
    logic i_rst_n;

    dts_item_if   item_ch ();
    dts_result_if result_ch ();
    dts_cfg_if    cfg_ch ();

    distance_transform_skeleton_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_ch),
        .o_out   (result_ch),
        .i_cfg   (cfg_ch)
    );

    logic [DIST_W-1:0]     shadow_dist [MAP_W*MAP_H];
    logic                  shadow_empty;
    logic [CFG_DATA_W-1:0] img_width;
    logic [CFG_DATA_W-1:0] img_height;

    t_pixel_result pending_results [$];
    int            mismatches;
    int            scored_items;
    int            cycles;
    int            send_idle_pct;
    int            recv_idle_pct;

    initial begin
        i_clk = 1'b0;
    end

    always #5ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int eff_w();
        return (img_width > MAP_W) ? MAP_W : int'(img_width);
    endfunction

    function automatic int eff_h();
        return (img_height > MAP_H) ? MAP_H : int'(img_height);
    endfunction

    function automatic int dist_at(int r, int c);
        if (r < 0 || c < 0 || r >= eff_h() || c >= eff_w())
            return 0;
        return int'(shadow_dist[r*MAP_W + c]);
    endfunction

    function automatic int min_of(int a, int b);
        return (a < b) ? a : b;
    endfunction

    // two-pass city-block transform in place; returns 1 when no foreground was seen
    function automatic logic transform_map();
        int   w;
        int   h;
        int   v;
        int   k;
        logic any;
        w   = eff_w();
        h   = eff_h();
        any = 1'b0;
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                k = r*MAP_W + c;
                if (shadow_dist[k] != 0) begin
                    v   = min_of(dist_at(r - 1, c), dist_at(r, c - 1)) + 1;
                    any = 1'b1;
                    shadow_dist[k] = (v > 255) ? DIST_MAX : v[DIST_W-1:0];
                end
            end
        end
        for (int r = h - 1; r >= 0; r--) begin
            for (int c = w - 1; c >= 0; c--) begin
                k = r*MAP_W + c;
                v = min_of(dist_at(r, c + 1), dist_at(r + 1, c)) + 1;
                if (v < int'(shadow_dist[k]))
                    shadow_dist[k] = v[DIST_W-1:0];
            end
        end
        return !any;
    endfunction

    function automatic t_pixel_result compute_pixel_result(logic [OPCODE_W-1:0] op, int r,
                                                           int c, logic on);
        t_pixel_result res;
        logic          in_img;
        int            d;
        int            s;
        res    = '0;
        in_img = (r < eff_h()) && (c < eff_w());
        case (op)
            OP_WRITE: begin
                if (in_img)
                    shadow_dist[r*MAP_W + c] = {{(DIST_W-1){1'b0}}, on};
            end
            OP_RUN: begin
                shadow_empty = transform_map();
                res.status   = shadow_empty;
            end
            OP_READ: begin
                if (in_img) begin
                    d        = dist_at(r, c);
                    res.dval = d[DIST_W-1:0];
                    if (d != 0) begin
                        s = dist_at(r, c - 2) + dist_at(r, c + 2) + dist_at(r - 2, c)
                          + dist_at(r + 2, c) - 4*d;
                        if (s <= SKEL_LIMIT)
                            res.skel = d[DIST_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // entered at a falling edge, returns at a falling edge with valid still high
    task automatic send_item(logic [OPCODE_W-1:0] op, int r, int c, logic on,
                             logic typed, t_pixel_result typed_res);
        t_pixel_result res;
        logic          counts;
        cfg_ch.valid <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.opcode    <= op;
        item_ch.pixel_row <= r[COORD_W-1:0];
        item_ch.pixel_col <= c[COORD_W-1:0];
        item_ch.pixel_on  <= on;
        do @(posedge i_clk); while (!item_ch.ready);
        counts = (op == OP_RUN) ||
                 ((op == OP_WRITE || op == OP_READ) && r < eff_h() && c < eff_w());
        res = compute_pixel_result(op, r, c, on);
        pending_results.push_back(typed ? typed_res : res);
        if (counts)
            scored_items++;
        if (scored_items < RANDOM_ITEMS/3) begin
            send_idle_pct = 28;
            recv_idle_pct = 54;
        end else if (scored_items < 2*RANDOM_ITEMS/3) begin
            send_idle_pct = 54;
            recv_idle_pct = 28;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        @(negedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, int data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == CFG_WIDTH)
            img_width = data[CFG_DATA_W-1:0];
        else
            img_height = data[CFG_DATA_W-1:0];
        @(negedge i_clk);
    endtask

    task automatic settle();
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic send_noise();
        int ew;
        int eh;
        int r;
        int c;
        int kind;
        ew   = eff_w();
        eh   = eff_h();
        r    = $urandom_range(0, 255);
        c    = $urandom_range(0, 255);
        kind = $urandom_range(0, 2);
        if (eh < MAP_H)
            r = $urandom_range(eh, 255);
        else if (ew < MAP_W)
            c = $urandom_range(ew, 255);
        else
            kind = 0;
        case (kind)
            0: send_item(OP_NONE, r, c, $urandom_range(0, 1), 1'b0, '0);
            1: send_item(OP_WRITE, r, c, $urandom_range(0, 1), 1'b0, '0);
            default: send_item(OP_READ, r, c, $urandom_range(0, 1), 1'b0, '0);
        endcase
    endtask

    task automatic read_pixels(int count);
        repeat (count) begin
            if ($urandom_range(0, 99) < 8)
                send_noise();
            send_item(OP_READ, $urandom_range(0, eff_h() - 1), $urandom_range(0, eff_w() - 1),
                      $urandom_range(0, 1), 1'b0, '0);
        end
    endtask

    task automatic run_phase(int w_set, int h_set);
        int ew;
        int eh;
        int on_pct;
        settle();
        write_cfg(CFG_WIDTH, w_set);
        write_cfg(CFG_HEIGHT, h_set);
        ew = eff_w();
        eh = eff_h();
        case ($urandom_range(0, 9))
            0:       on_pct = 0;
            1, 2:    on_pct = 100;
            3, 4, 5: on_pct = 40;
            default: on_pct = 80;
        endcase
        for (int r = 0; r < eh; r++) begin
            for (int c = 0; c < ew; c++) begin
                if ($urandom_range(0, 99) < 4)
                    send_noise();
                send_item(OP_WRITE, r, c, $urandom_range(0, 99) < on_pct, 1'b0, '0);
            end
        end
        repeat ($urandom_range(1, 3)) begin
            send_item(OP_RUN, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 1), 1'b0, '0);
            read_pixels(min_of(ew*eh, 20));
            repeat ($urandom_range(0, 4))
                send_item(OP_WRITE, $urandom_range(0, eh - 1), $urandom_range(0, ew - 1),
                          $urandom_range(0, 1), 1'b0, '0);
        end
        // shrink or keep the window over the map left by the runs and later writes
        if ($urandom_range(0, 3) == 0) begin
            settle();
            write_cfg(CFG_WIDTH, $urandom_range(1, ew));
            write_cfg(CFG_HEIGHT, $urandom_range(1, eh));
            read_pixels(8);
        end
    endtask

    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pixel_result want;
        t_pixel_result got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got = '{result_ch.distance_value, result_ch.skeleton_value, result_ch.status};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected beat: dist %0d skel %0d status %0d",
                             got.dval, got.skel, got.status);
            end else begin
                want = pending_results.pop_front();
                if (got.dval !== want.dval || got.skel !== want.skel ||
                    got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: exp dist %0d skel %0d status %0d, got %0d %0d %0d",
                                 want.dval, want.skel, want.status,
                                 got.dval, got.skel, got.status);
                end
            end
        end
    end

    initial begin
        int phase_no;
        t_dir_row row;
        cycles            = 0;
        mismatches        = 0;
        scored_items      = 0;
        send_idle_pct     = 28;
        recv_idle_pct     = 54;
        i_rst_n           = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.opcode    = OP_WRITE;
        item_ch.pixel_row = '0;
        item_ch.pixel_col = '0;
        item_ch.pixel_on  = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_WIDTH;
        cfg_ch.data       = '0;
        img_width         = IMG_DIM_RESET;
        img_height        = IMG_DIM_RESET;
        shadow_empty      = 1'b1;
        foreach (shadow_dist[k])
            shadow_dist[k] = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = DIRECTED[i];
            if (row.is_cfg) begin
                settle();
                write_cfg(t_cfg_idx'(row.idx), int'(row.data));
            end else begin
                send_item(row.op, int'(row.row), int'(row.col), row.on, row.typed,
                          '{row.dval, row.skel, row.status});
            end
        end

        scored_items = 0;
        phase_no     = 0;
        while (scored_items < RANDOM_ITEMS) begin
            case (phase_no)
                2:       run_phase(MAP_W, 1);
                5:       run_phase(1, 511);
                default: run_phase($urandom_range(1, 16), $urandom_range(1, 16));
            endcase
            phase_no++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
